/* src/dhfk_pkg.sv */
package dhfk_pkg;

    // Parameter defaults.
    localparam int ANGLE_WIDTH_DEF   = 16;
    localparam int ROT_FRAC_BITS_DEF = 14;

    // Field widths of the channels and of the configuration port.
    localparam int ANGLE_W = 16;
    localparam int ROT_OUT_W = 16;
    localparam int POS_OUT_W = 20;
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 3;

    // Internal number formats.
    localparam int NUM_LINKS = 5;
    localparam int TRIG_W = 32;
    localparam int ROT_W = 33;
    localparam int POS_W = 32;
    localparam int AP_W = 26;
    localparam int QT = 30;
    localparam int POS_FRAC = 8;

    // Pipeline depths.
    localparam int SIN_LAT = 6;
    localparam int CELL_LAT = 3;
    localparam int CHAIN_LAT = SIN_LAT + NUM_LINKS * CELL_LAT;

    // Odd polynomial coefficients of the quarter-turn sine, Q30.
    localparam logic [30:0] SIN_C9 = 31'd172272;
    localparam logic [30:0] SIN_COEF [0:3] = '{31'd5026995, 31'd85569306,
                                                31'd693598668, 31'd1686629713};

    // Configuration register indexes and reset values.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_HEIGHT      = 3'd0,
        CFG_SHOULDER_OFFSET  = 3'd1,
        CFG_UPPER_ARM_LENGTH = 3'd2,
        CFG_FOREARM_LENGTH   = 3'd3,
        CFG_WRIST_TOOL_LEN   = 3'd4
    } cfg_idx_t;

    localparam logic [CFG_W-1:0] RST_BASE_HEIGHT      = 16'd3469;
    localparam logic [CFG_W-1:0] RST_SHOULDER_OFFSET  = 16'd1952;
    localparam logic [CFG_W-1:0] RST_UPPER_ARM_LENGTH = 16'd7430;
    localparam logic [CFG_W-1:0] RST_FOREARM_LENGTH   = 16'd8608;
    localparam logic [CFG_W-1:0] RST_WRIST_TOOL_LEN   = 16'd10240;

    // Fixed link twists as cosine and sine signs, and the quarter turn.
    localparam int LINK_CA [0:NUM_LINKS-1] = '{0, 1, 1, 0, 1};
    localparam int LINK_SA [0:NUM_LINKS-1] = '{1, 0, 0, -1, 0};
    localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

    // Data that walks down the chain of link cells.
    typedef struct packed {
        logic [2:0][2:0][ROT_W-1:0]     r;
        logic [2:0][POS_W-1:0]          p;
        logic [NUM_LINKS-1:0][TRIG_W-1:0] ct;
        logic [NUM_LINKS-1:0][TRIG_W-1:0] st;
    } link_data_t;

    // Round to nearest with ties away from zero, dropping n bits.
    function automatic logic signed [63:0] rshr(input logic signed [63:0] v,
                                                 input int unsigned n);
        logic [63:0] half;
        logic [63:0] mag;
        half = 64'd1 << (n - 1);
        mag = v[63] ? 64'(-v) : 64'(v);
        mag = (mag + half) >> n;
        rshr = v[63] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [63:0] sat(input logic signed [63:0] v,
                                                input logic signed [63:0] lo,
                                                input logic signed [63:0] hi);
        sat = (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Multiply by a fixed sign of -1, 0 or +1.
    function automatic logic signed [63:0] scale(input logic signed [63:0] v,
                                                  input int c);
        scale = (c == 1) ? v : ((c == -1) ? -v : 64'sd0);
    endfunction

endpackage

/* src/dhfk_if.sv */
interface dhfk_joint_if
    import dhfk_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] base_angle;
    logic signed [ANGLE_W-1:0] shoulder_angle;
    logic signed [ANGLE_W-1:0] elbow_angle;
    logic signed [ANGLE_W-1:0] wrist_pitch_angle;
    logic signed [ANGLE_W-1:0] wrist_roll_angle;

    modport source (output valid, base_angle, shoulder_angle, elbow_angle,
                    wrist_pitch_angle, wrist_roll_angle, input ready);
    modport sink (input valid, base_angle, shoulder_angle, elbow_angle,
                  wrist_pitch_angle, wrist_roll_angle, output ready);
endinterface

interface dhfk_pose_if
    import dhfk_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic signed [ROT_OUT_W-1:0] rot_xx;
    logic signed [ROT_OUT_W-1:0] rot_xy;
    logic signed [ROT_OUT_W-1:0] rot_xz;
    logic signed [ROT_OUT_W-1:0] rot_yx;
    logic signed [ROT_OUT_W-1:0] rot_yy;
    logic signed [ROT_OUT_W-1:0] rot_yz;
    logic signed [ROT_OUT_W-1:0] rot_zx;
    logic signed [ROT_OUT_W-1:0] rot_zy;
    logic signed [ROT_OUT_W-1:0] rot_zz;
    logic signed [POS_OUT_W-1:0] pos_x;
    logic signed [POS_OUT_W-1:0] pos_y;
    logic signed [POS_OUT_W-1:0] pos_z;

    modport source (output valid, rot_xx, rot_xy, rot_xz, rot_yx, rot_yy, rot_yz,
                    rot_zx, rot_zy, rot_zz, pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, rot_xx, rot_xy, rot_xz, rot_yx, rot_yy, rot_yz,
                  rot_zx, rot_zy, rot_zz, pos_x, pos_y, pos_z, output ready);
endinterface

/* src/dh_forward_kinematics_5dof.sv */
// Forward kinematics of a five-axis arm by standard Denavit-Hartenberg chaining.
// Channel joints (sink) carries five signed binary joint angles, full scale +-pi.
// Channel pose (source) carries the nine rotation entries (Q2.ROT_FRAC_BITS) and
// the x, y, z position in 1/64 mm, saturated at the field ranges.
// Link offsets and lengths sit in five registers written through cfg_we,
// cfg_index and cfg_data; write them only while no transaction is in flight.
// An accepted joints transaction reaches pose valid through the pipelined sine
// and cosine, stages A, B and C of each of the five link cells, and the output
// register. Throughput is one transaction per cycle while the receiver does not
// stall; every stage advances together.
// When the receiver stalls, the output register holds its transaction and the
// whole pipeline freezes, so joints.ready drops in the same cycle.
// Reset clears all valid bits and loads the register reset values; no
// clearing pass is needed.
module dh_forward_kinematics_5dof
    import dhfk_pkg::*;
#(
    parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
    parameter int ROT_FRAC_BITS = ROT_FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    dhfk_joint_if.sink           joints,
    dhfk_pose_if.source          pose,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [CFG_W-1:0] base_height_reg, shoulder_offset_reg, upper_arm_length_reg;
    logic [CFG_W-1:0] forearm_length_reg, wrist_tool_len_reg;

    logic [CHAIN_LAT-1:0] vld_reg;
    logic                 out_valid_reg;
    logic                 en;

    logic [NUM_LINKS-1:0][ANGLE_W-1:0] angle;
    logic [NUM_LINKS-1:0][31:0]        turn;
    logic [NUM_LINKS-1:0][TRIG_W-1:0]  sin_val, cos_val;
    logic [NUM_LINKS-1:0][CFG_W-1:0]   link_d, link_a;
    link_data_t chain [0:NUM_LINKS];

    logic signed [ROT_OUT_W-1:0] rot_reg [0:8];
    logic signed [POS_OUT_W-1:0] pos_reg [0:2];
    logic signed [ROT_OUT_W-1:0] rot_next [0:8];
    logic signed [POS_OUT_W-1:0] pos_next [0:2];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_height_reg <= RST_BASE_HEIGHT;
            shoulder_offset_reg <= RST_SHOULDER_OFFSET;
            upper_arm_length_reg <= RST_UPPER_ARM_LENGTH;
            forearm_length_reg <= RST_FOREARM_LENGTH;
            wrist_tool_len_reg <= RST_WRIST_TOOL_LEN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASE_HEIGHT:      base_height_reg <= cfg_data;
                CFG_SHOULDER_OFFSET:  shoulder_offset_reg <= cfg_data;
                CFG_UPPER_ARM_LENGTH: upper_arm_length_reg <= cfg_data;
                CFG_FOREARM_LENGTH:   forearm_length_reg <= cfg_data;
                CFG_WRIST_TOOL_LEN:   wrist_tool_len_reg <= cfg_data;
                default:              ;
            endcase
        end
    end

    assign link_d = {wrist_tool_len_reg, {CFG_W{1'b0}}, {CFG_W{1'b0}}, {CFG_W{1'b0}},
                     base_height_reg};
    assign link_a = {{CFG_W{1'b0}}, {CFG_W{1'b0}}, forearm_length_reg,
                     upper_arm_length_reg, shoulder_offset_reg};

    // The pipeline moves whenever the output register is free or being taken.
    assign en = !out_valid_reg || pose.ready;
    assign joints.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[CHAIN_LAT-2:0], joints.valid};
            out_valid_reg <= vld_reg[CHAIN_LAT-1];
        end
    end

    // Angles as 32-bit turns; joint four carries a quarter-turn offset.
    assign angle = {joints.wrist_roll_angle, joints.wrist_pitch_angle,
                    joints.elbow_angle, joints.shoulder_angle, joints.base_angle};

    for (genvar k = 0; k < NUM_LINKS; k++)
    begin : g_trig
        logic [31:0] masked;
        always_comb
        begin
            masked = {{(32 - ANGLE_W){1'b0}}, angle[k]} & ((32'd1 << ANGLE_WIDTH) - 32'd1);
            turn[k] = (masked << (32 - ANGLE_WIDTH)) - ((k == 3) ? QUARTER_TURN : 32'd0);
        end

        dhfk_sine u_sin (
            .clk   (clk),
            .en    (en),
            .turn  (turn[k]),
            .value (sin_val[k])
        );

        dhfk_sine u_cos (
            .clk   (clk),
            .en    (en),
            .turn  (turn[k] + QUARTER_TURN),
            .value (cos_val[k])
        );
    end

    // Identity rotation and zero position enter the chain with all link angles.
    always_comb
    begin
        chain[0].r = '0;
        for (int i = 0; i < 3; i++)
        begin
            chain[0].r[i][i] = ROT_W'(64'sd1 <<< QT);
        end
        chain[0].p = '0;
        chain[0].ct = cos_val;
        chain[0].st = sin_val;
    end

    for (genvar k = 0; k < NUM_LINKS; k++)
    begin : g_link
        dhfk_link_cell #(
            .K  (k),
            .CA (LINK_CA[k]),
            .SA (LINK_SA[k])
        ) u_cell (
            .clk      (clk),
            .en       (en),
            .link_d   (link_d[k]),
            .link_a   (link_a[k]),
            .data_in  (chain[k]),
            .data_out (chain[k+1])
        );
    end

    // Final rounding and saturation into the output register.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                rot_next[i*3+j] = ROT_OUT_W'(sat(
                    rshr(64'($signed(chain[NUM_LINKS].r[i][j])), QT - ROT_FRAC_BITS),
                    -(64'sd1 <<< ROT_FRAC_BITS), 64'sd1 <<< ROT_FRAC_BITS));
            end
            pos_next[i] = POS_OUT_W'(sat(
                rshr(64'($signed(chain[NUM_LINKS].p[i])), POS_FRAC),
                -64'sd524288, 64'sd524287));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_reg <= rot_next;
            pos_reg <= pos_next;
        end
    end

    assign pose.valid = out_valid_reg;
    assign pose.rot_xx = rot_reg[0];
    assign pose.rot_xy = rot_reg[1];
    assign pose.rot_xz = rot_reg[2];
    assign pose.rot_yx = rot_reg[3];
    assign pose.rot_yy = rot_reg[4];
    assign pose.rot_yz = rot_reg[5];
    assign pose.rot_zx = rot_reg[6];
    assign pose.rot_zy = rot_reg[7];
    assign pose.rot_zz = rot_reg[8];
    assign pose.pos_x = pos_reg[0];
    assign pose.pos_y = pos_reg[1];
    assign pose.pos_z = pos_reg[2];

endmodule

/* src/dhfk_sine.sv */
module dhfk_sine
    import dhfk_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [31:0]              turn,
    output logic signed [TRIG_W-1:0] value
);

    logic [30:0] x_reg [0:4];
    logic        neg_reg [0:4];
    logic [30:0] u_reg [0:3];
    logic [30:0] p_reg [1:4];
    logic signed [TRIG_W-1:0] s_reg;

    logic [30:0] x_next;
    logic [61:0] sq_next;
    logic [61:0] fin_prod;
    logic [31:0] fin_mag;

    // Fold the turn into the first quadrant and square the fraction.
    always_comb
    begin
        x_next = turn[30] ? (31'h4000_0000 - {1'b0, turn[29:0]}) : {1'b0, turn[29:0]};
        sq_next = 62'(x_next) * 62'(x_next);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0] <= x_next;
            neg_reg[0] <= turn[31];
            u_reg[0] <= sq_next[60:30];
        end
    end

    // One Horner step per stage.
    for (genvar j = 1; j <= 4; j++)
    begin : g_horner
        logic [61:0] prod;
        logic [31:0] p_next;
        always_comb
        begin
            prod = 62'(u_reg[j-1]) * 62'((j == 1) ? SIN_C9 : p_reg[j == 1 ? 2 : j-1]);
            p_next = {1'b0, SIN_COEF[j-1]} - prod[61:30];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[j] <= p_next[30:0];
                x_reg[j] <= x_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                if (j < 4)
                begin
                    u_reg[j < 4 ? j : 3] <= u_reg[j-1];
                end
            end
        end
    end

    // Final multiply by the fraction and sign.
    always_comb
    begin
        fin_prod = 62'(x_reg[4]) * 62'(p_reg[4]);
        fin_mag = fin_prod[61:30];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg <= neg_reg[4] ? -$signed(fin_mag) : $signed(fin_mag);
        end
    end

    assign value = s_reg;

endmodule

/* src/dhfk_link_cell.sv */
module dhfk_link_cell
    import dhfk_pkg::*;
#(
    parameter int K  = 0,
    parameter int CA = 1,
    parameter int SA = 0
)
(
    input  logic             clk,
    input  logic             en,
    input  logic [CFG_W-1:0] link_d,
    input  logic [CFG_W-1:0] link_a,
    input  link_data_t       data_in,
    output link_data_t       data_out
);

    link_data_t s1_reg;
    link_data_t s2_reg;
    link_data_t s3_reg;

    logic signed [AP_W-1:0] ap0_reg, ap1_reg;
    logic signed [63:0] pc_reg [0:2][0:1];
    logic signed [63:0] ps_reg [0:2][0:1];
    logic signed [63:0] q_reg [0:2][0:2];

    logic signed [TRIG_W-1:0] ct, st;
    logic signed [63:0] a_ct, a_st;
    logic signed [63:0] pc_next [0:2][0:1];
    logic signed [63:0] ps_next [0:2][0:1];
    logic signed [AP_W-1:0] ap2;
    logic signed [63:0] q_next [0:2][0:2];
    link_data_t s2_next;
    link_data_t s3_next;

    // Stage A: link vector and rotation products with cosine and sine.
    always_comb
    begin
        ct = $signed(data_in.ct[K]);
        st = $signed(data_in.st[K]);
        a_ct = $signed({1'b0, link_a}) * ct;
        a_st = $signed({1'b0, link_a}) * st;
        for (int i = 0; i < 3; i++)
        begin
            for (int c = 0; c < 2; c++)
            begin
                pc_next[i][c] = $signed(data_in.r[i][c]) * ct;
                ps_next[i][c] = $signed(data_in.r[i][c]) * st;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= data_in;
            ap0_reg <= AP_W'(rshr(a_ct, QT - POS_FRAC));
            ap1_reg <= AP_W'(rshr(a_st, QT - POS_FRAC));
            pc_reg <= pc_next;
            ps_reg <= ps_next;
        end
    end

    // Stage B: new rotation, and products of the old rotation with the link vector.
    always_comb
    begin
        ap2 = $signed({2'b00, link_d, 8'h00});
        s2_next = s1_reg;
        for (int i = 0; i < 3; i++)
        begin
            logic signed [63:0] r2q;
            r2q = 64'($signed(s1_reg.r[i][2])) <<< QT;
            s2_next.r[i][0] = ROT_W'(rshr(pc_reg[i][0] + ps_reg[i][1], QT));
            s2_next.r[i][1] = ROT_W'(rshr(scale(pc_reg[i][1] - ps_reg[i][0], CA)
                                          + scale(r2q, SA), QT));
            s2_next.r[i][2] = ROT_W'(rshr(scale(ps_reg[i][0] - pc_reg[i][1], SA)
                                          + scale(r2q, CA), QT));
            q_next[i][0] = $signed(s1_reg.r[i][0]) * ap0_reg;
            q_next[i][1] = $signed(s1_reg.r[i][1]) * ap1_reg;
            q_next[i][2] = $signed(s1_reg.r[i][2]) * ap2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s2_next;
            q_reg <= q_next;
        end
    end

    // Stage C: accumulate the position.
    always_comb
    begin
        s3_next = s2_reg;
        for (int i = 0; i < 3; i++)
        begin
            s3_next.p[i] = POS_W'($signed(s2_reg.p[i])
                                  + rshr(q_reg[i][0] + q_reg[i][1] + q_reg[i][2], QT));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg <= s3_next;
        end
    end

    assign data_out = s3_reg;

endmodule

/* src/dhfk_checker.sv */
module dhfk_checker
    import dhfk_pkg::*;
#(
    parameter int ROT_FRAC_BITS = ROT_FRAC_BITS_DEF
)
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        joint_ready,
    input logic                        pose_valid,
    input logic                        pose_ready,
    input logic signed [ROT_OUT_W-1:0] rot_xx,
    input logic signed [ROT_OUT_W-1:0] rot_yy,
    input logic signed [ROT_OUT_W-1:0] rot_zz,
    input logic signed [POS_OUT_W-1:0] pos_x
);

    // An empty output stage never blocks the input.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !pose_valid |-> joint_ready)
        else $error("joints not ready with empty output stage");

    // A stalled output freezes the pipeline and the input.
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        pose_valid && !pose_ready |-> !joint_ready)
        else $error("joints accepted while pose stalled");

    // A stalled pose transaction holds.
    a_pose_holds: assert property (@(posedge clk) disable iff (!rst_n)
        pose_valid && !pose_ready |=> pose_valid && $stable(pos_x) && $stable(rot_xx))
        else $error("pose changed while stalled");

    // Diagonal rotation entries stay within plus or minus one (checked for ROT_FRAC_BITS up to 14).
    a_rot_range: assert property (@(posedge clk) disable iff (!rst_n)
        pose_valid |-> (ROT_FRAC_BITS > 14) ||
            ((rot_xx >= -(16'sd1 <<< ROT_FRAC_BITS)) && (rot_xx <= (16'sd1 <<< ROT_FRAC_BITS))
          && (rot_yy >= -(16'sd1 <<< ROT_FRAC_BITS)) && (rot_yy <= (16'sd1 <<< ROT_FRAC_BITS))
          && (rot_zz >= -(16'sd1 <<< ROT_FRAC_BITS)) && (rot_zz <= (16'sd1 <<< ROT_FRAC_BITS))))
        else $error("rotation entry out of range");

    // No pose transaction is offered during reset.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !pose_valid)
        else $error("pose valid during reset");

endmodule

bind dh_forward_kinematics_5dof dhfk_checker #(
    .ROT_FRAC_BITS (ROT_FRAC_BITS)
) u_dhfk_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .joint_ready (joints.ready),
    .pose_valid  (pose.valid),
    .pose_ready  (pose.ready),
    .rot_xx      (pose.rot_xx),
    .rot_yy      (pose.rot_yy),
    .rot_zz      (pose.rot_zz),
    .pos_x       (pose.pos_x)
);

/* test/dh_forward_kinematics_5dof_tb.sv */
module dh_forward_kinematics_5dof_tb;
    import dhfk_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [15:0] rot [0:8];
        logic [19:0] pos [0:2];
    } pose_t;

    typedef struct {
        logic [15:0] ang [0:4];
        bit          typed;
        logic [15:0] rot [0:8];
        logic [19:0] pos [0:2];
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    dhfk_joint_if joints ();
    dhfk_pose_if pose ();

    dh_forward_kinematics_5dof dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .joints    (joints.sink),
        .pose      (pose.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the link registers.
    longint link_reg [0:4];

    // Field names for mismatch reports.
    string rot_field [0:8] = '{"rot_xx", "rot_xy", "rot_xz", "rot_yx", "rot_yy",
                               "rot_yz", "rot_zx", "rot_zy", "rot_zz"};
    string pos_field [0:2] = '{"pos_x", "pos_y", "pos_z"};

    pose_t pending_poses [$];
    int fail_count;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;
    int quiet_cycles;

    // Clock.
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint round_shift(longint v, int n);
        longint half;
        half = longint'(1) << (n - 1);
        if (v >= 0)
            return (v + half) >>> n;
        return -((-v + half) >>> n);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Quarter-wave sine polynomial on a Q30 quarter-turn fraction.
    function automatic longint quarter_wave(longint unsigned x);
        longint unsigned u;
        longint unsigned p;
        u = (x * x) >> 30;
        p = 64'd172272;
        p = 64'd5026995 - ((u * p) >> 30);
        p = 64'd85569306 - ((u * p) >> 30);
        p = 64'd693598668 - ((u * p) >> 30);
        p = 64'd1686629713 - ((u * p) >> 30);
        return longint'((x * p) >> 30);
    endfunction

    function automatic longint turn_sine(logic [31:0] t);
        longint unsigned r;
        longint s;
        r = t[29:0];
        if (t[30])
            r = 64'h4000_0000 - r;
        s = quarter_wave(r);
        return t[31] ? -s : s;
    endfunction

    // Apply one Denavit-Hartenberg link to the running pose.
    function automatic void apply_link(inout longint r [0:2][0:2], inout longint p [0:2],
                                       input logic [31:0] t, input longint d,
                                       input longint a, input int ca, input int sa);
        longint ct;
        longint st;
        longint ar [0:2][0:2];
        longint ap [0:2];
        longint nr [0:2][0:2];
        longint acc;
        ct = turn_sine(t + 32'h4000_0000);
        st = turn_sine(t);
        ar[0][0] = ct; ar[0][1] = -st * ca; ar[0][2] = st * sa;
        ar[1][0] = st; ar[1][1] = ct * ca;  ar[1][2] = -ct * sa;
        ar[2][0] = 0;  ar[2][1] = (longint'(1) << 30) * sa;
        ar[2][2] = (longint'(1) << 30) * ca;
        ap[0] = round_shift(a * ct, 22);
        ap[1] = round_shift(a * st, 22);
        ap[2] = d <<< 8;
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int k = 0; k < 3; k++)
                acc += r[i][k] * ap[k];
            p[i] += round_shift(acc, 30);
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++)
                    acc += r[i][k] * ar[k][j];
                nr[i][j] = round_shift(acc, 30);
            end
        r = nr;
    endfunction

    // End-effector pose for one set of joint angles.
    function automatic pose_t end_effector_pose(logic [15:0] ang [0:4]);
        longint r [0:2][0:2];
        longint p [0:2];
        pose_t res;
        r = '{'{longint'(1) << 30, 0, 0}, '{0, longint'(1) << 30, 0},
              '{0, 0, longint'(1) << 30}};
        p = '{0, 0, 0};
        apply_link(r, p, {ang[0], 16'h0}, link_reg[0], link_reg[1], 0, 1);
        apply_link(r, p, {ang[1], 16'h0}, 0, link_reg[2], 1, 0);
        apply_link(r, p, {ang[2], 16'h0}, 0, link_reg[3], 1, 0);
        apply_link(r, p, {ang[3], 16'h0} - 32'h4000_0000, 0, 0, 0, -1);
        apply_link(r, p, {ang[4], 16'h0}, link_reg[4], 0, 1, 0);
        for (int i = 0; i < 9; i++)
            res.rot[i] = 16'(clamp(round_shift(r[i / 3][i % 3], 16), -16384, 16384));
        for (int i = 0; i < 3; i++)
            res.pos[i] = 20'(clamp(round_shift(p[i], 8), -524288, 524287));
        return res;
    endfunction

    task automatic write_link_reg(cfg_idx_t idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        link_reg[idx] = val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one transaction and wait for it to be taken.
    task automatic send_angles(logic [15:0] ang [0:4]);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            joints.valid <= 1'b0;
            @(posedge clk);
        end
        joints.valid <= 1'b1;
        joints.base_angle <= ang[0];
        joints.shoulder_angle <= ang[1];
        joints.elbow_angle <= ang[2];
        joints.wrist_pitch_angle <= ang[3];
        joints.wrist_roll_angle <= ang[4];
        do
            @(posedge clk);
        while (!joints.ready);
    endtask

    task automatic wait_drained();
        joints.valid <= 1'b0;
        while (pending_poses.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_checked(logic [15:0] ang [0:4]);
        pending_poses.push_back(end_effector_pose(ang));
        send_angles(ang);
    endtask

    task automatic random_burst(int n);
        logic [15:0] ang [0:4];
        for (int i = 0; i < n; i++)
        begin
            for (int j = 0; j < 5; j++)
                ang[j] = ($urandom_range(3, 0) == 0) ?
                         16'($urandom_range(7, 0) * 16'h2000 + $urandom_range(2, 0) - 1) :
                         16'($urandom);
            send_checked(ang);
        end
    endtask

    // Receiver ready with random idling and one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pose.ready <= 1'b0;
        else if (hold_off)
            pose.ready <= 1'b0;
        else
            pose.ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
    end

    // Compare each pose transaction with the oldest expectation.
    always @(posedge clk)
    begin
        pose_t want;
        logic [15:0] got_rot [0:9];
        logic [19:0] got_pos [0:2];
        if (rst_n && pose.valid && pose.ready)
        begin
            got_rot = '{pose.rot_xx, pose.rot_xy, pose.rot_xz, pose.rot_yx, pose.rot_yy,
                        pose.rot_yz, pose.rot_zx, pose.rot_zy, pose.rot_zz, 16'h0};
            got_pos = '{pose.pos_x, pose.pos_y, pose.pos_z};
            if (pending_poses.size() == 0)
            begin
                $error("pose transaction with nothing expected");
                fail_count++;
            end
            else
            begin
                want = pending_poses.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got_rot[i] !== want.rot[i])
                    begin
                        $error("%s expected %0d got %0d", rot_field[i],
                               $signed(want.rot[i]), $signed(got_rot[i]));
                        fail_count++;
                    end
                for (int i = 0; i < 3; i++)
                    if (got_pos[i] !== want.pos[i])
                    begin
                        $error("%s expected %0d got %0d", pos_field[i],
                               $signed(want.pos[i]), $signed(got_pos[i]));
                        fail_count++;
                    end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if ((joints.valid && joints.ready) || (pose.valid && pose.ready) || hold_off)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Long receiver hold-off while the sender keeps offering.
    task automatic pressure_test();
        hold_off = 1'b1;
        fork
            random_burst(60);
            begin
                repeat (200) @(posedge clk);
                hold_off = 1'b0;
            end
        join
    endtask

    initial
    begin
        stim_row_t rows [$];
        stim_row_t row;
        logic [15:0] lim [0:4];
        fail_count = 0;
        quiet_cycles = 0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_BASE_HEIGHT;
        cfg_data = '0;
        joints.valid = 1'b0;
        joints.base_angle = '0;
        joints.shoulder_angle = '0;
        joints.elbow_angle = '0;
        joints.wrist_pitch_angle = '0;
        joints.wrist_roll_angle = '0;
        link_reg = '{3469, 1952, 7430, 8608, 10240};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; the all-zero pose after reset is typed in.
        // Zero angles: z up, x along the arm, wrist pitch at -pi/2.
        row.ang = '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0};
        row.typed = 1'b1;
        row.rot = '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0,
                    -16'sd16384, 16'sd0, 16'sd0};
        row.pos = '{20'sd28230, 20'sd0, 20'sd3469};
        rows.push_back(row);
        row.typed = 1'b0;
        lim = '{16'h7FFF, 16'h8000, 16'h4000, 16'hC000, 16'hFFFF};
        for (int k = 0; k < 5; k++)
        begin
            for (int j = 0; j < 5; j++)
                row.ang[j] = lim[(j + k) % 5];
            rows.push_back(row);
        end
        for (int j = 0; j < 5; j++)
        begin
            row.ang = '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0};
            row.ang[j] = 16'h8000;
            rows.push_back(row);
            row.ang[j] = 16'h4000;
            rows.push_back(row);
            row.ang[j] = 16'h0001;
            rows.push_back(row);
        end
        foreach (rows[i])
        begin
            if (rows[i].typed)
                pending_poses.push_back('{rot: rows[i].rot, pos: rows[i].pos});
            else
                pending_poses.push_back(end_effector_pose(rows[i].ang));
            send_angles(rows[i].ang);
        end
        wait_drained();

        // Register extremes: all zero, then all full scale.
        for (int i = 0; i < 5; i++)
            write_link_reg(cfg_idx_t'(i), 16'h0000);
        random_burst(20);
        wait_drained();
        for (int i = 0; i < 5; i++)
            write_link_reg(cfg_idx_t'(i), 16'hFFFF);
        random_burst(30);
        wait_drained();

        // Random phases with idling on each side and random registers.
        send_idle_pct = 25;
        recv_idle_pct = 87;
        for (int i = 0; i < 5; i++)
            write_link_reg(cfg_idx_t'(i), 16'($urandom));
        random_burst(130);
        wait_drained();
        send_idle_pct = 87;
        recv_idle_pct = 25;
        for (int i = 0; i < 5; i++)
            write_link_reg(cfg_idx_t'(i), 16'($urandom_range(16000, 0)));
        random_burst(130);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_link_reg(CFG_BASE_HEIGHT, RST_BASE_HEIGHT);
        write_link_reg(CFG_SHOULDER_OFFSET, RST_SHOULDER_OFFSET);
        write_link_reg(CFG_UPPER_ARM_LENGTH, RST_UPPER_ARM_LENGTH);
        write_link_reg(CFG_FOREARM_LENGTH, RST_FOREARM_LENGTH);
        write_link_reg(CFG_WRIST_TOOL_LEN, RST_WRIST_TOOL_LEN);
        pressure_test();
        random_burst(100);
        wait_drained();

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
